@@ hw/rtl/mme_pkg.sv @@
// Shared constants, codes and control types of the matrix multiply engine.
package mme_pkg;

	localparam int MAX_SIZE_DEF      = 8;
	localparam int ELEMENT_WIDTH_DEF = 16;

	localparam int VALUE_W     = 16;
	localparam int IDX_PORT_W  = 3;
	localparam int ACC_W       = 35;
	localparam int CFG_W       = 4;
	localparam int CFG_INDEX_W = 2;
	localparam int CMD_W       = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	localparam logic [CFG_INDEX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_ROWS = 2'd1;

	localparam logic [CFG_W-1:0] MATRIX_SIZE_RST = 4'd8;
	localparam logic [CFG_W-1:0] ACTIVE_ROWS_RST = 4'd8;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} command_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic rd_en;
		logic first;
		logic emit;
		logic last;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} dp_status_t;

endpackage

@@ hw/rtl/mme_ctrl.sv @@
// Controller: configuration registers, loop counters and the sequencing state machine.
module mme_ctrl #(
	parameter int MAX_SIZE = mme_pkg::MAX_SIZE_DEF,
	parameter int IDX_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [mme_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                 in_valid,
	input  logic [mme_pkg::CMD_W-1:0]            in_cmd,
	output logic                                 in_ready,
	output mme_pkg::dp_cmd_t                     dp_cmd,
	input  mme_pkg::dp_status_t                  dp_status,
	output logic [IDX_W-1:0]                     row_idx,
	output logic [IDX_W-1:0]                     col_idx,
	output logic [IDX_W-1:0]                     k_idx
);

	localparam logic [mme_pkg::CFG_W-1:0] MAX_N = mme_pkg::CFG_W'(MAX_SIZE);

	logic [mme_pkg::CFG_W-1:0] matrix_size_q;
	logic [mme_pkg::CFG_W-1:0] active_rows_q;
	logic [mme_pkg::CFG_W-1:0] n_eff;
	logic [mme_pkg::CFG_W-1:0] rows_eff;
	mme_pkg::state_t           state_q;
	mme_pkg::state_t           state_d;
	logic [IDX_W-1:0]          i_q, i_d;
	logic [IDX_W-1:0]          j_q, j_d;
	logic [IDX_W-1:0]          k_q, k_d;
	logic                      k_end;
	logic                      j_end;
	logic                      i_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= mme_pkg::MATRIX_SIZE_RST;
			active_rows_q <= mme_pkg::ACTIVE_ROWS_RST;
		end else if (cfg_valid) begin
			if (cfg_index == mme_pkg::CFG_MATRIX_SIZE) begin
				matrix_size_q <= cfg_data;
			end else if (cfg_index == mme_pkg::CFG_ACTIVE_ROWS) begin
				active_rows_q <= cfg_data;
			end
		end
	end

	assign n_eff    = (matrix_size_q > MAX_N) ? MAX_N : matrix_size_q;
	assign rows_eff = (active_rows_q > n_eff) ? n_eff : active_rows_q;

	assign k_end = (mme_pkg::CFG_W'(k_q) == n_eff - 4'd1);
	assign j_end = (mme_pkg::CFG_W'(j_q) == n_eff - 4'd1);
	assign i_end = (mme_pkg::CFG_W'(i_q) == rows_eff - 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		j_d          = j_q;
		k_d          = k_q;
		in_ready     = 1'b0;
		dp_cmd.rd_en = 1'b0;
		dp_cmd.first = (k_q == '0);
		dp_cmd.emit  = 1'b0;
		dp_cmd.last  = i_end && j_end;
		case (state_q)
			mme_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				i_d = '0;
				j_d = '0;
				k_d = '0;
				if (in_valid && in_cmd == mme_pkg::CMD_COMPUTE &&
				    n_eff != 4'd0 && rows_eff != 4'd0) begin
					state_d = mme_pkg::ST_ISSUE;
				end
			end
			mme_pkg::ST_ISSUE: begin
				dp_cmd.rd_en = 1'b1;
				if (k_end) begin
					k_d     = '0;
					state_d = mme_pkg::ST_DRAIN;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			mme_pkg::ST_DRAIN: begin
				if (!dp_status.pipe_busy) begin
					state_d = mme_pkg::ST_EMIT;
				end
			end
			mme_pkg::ST_EMIT: begin
				if (dp_status.out_free) begin
					dp_cmd.emit = 1'b1;
					if (j_end) begin
						j_d = '0;
						if (i_end) begin
							state_d = mme_pkg::ST_IDLE;
						end else begin
							i_d     = i_q + 1'b1;
							state_d = mme_pkg::ST_ISSUE;
						end
					end else begin
						j_d     = j_q + 1'b1;
						state_d = mme_pkg::ST_ISSUE;
					end
				end
			end
			default: begin
				state_d = mme_pkg::ST_IDLE;
			end
		endcase
	end

	assign row_idx = i_q;
	assign col_idx = j_q;
	assign k_idx   = k_q;

endmodule

@@ hw/rtl/mme_datapath.sv @@
// Datapath: element memories for A and B, multiply-accumulate pipeline and result register.
module mme_datapath #(
	parameter int MAX_SIZE      = mme_pkg::MAX_SIZE_DEF,
	parameter int ELEMENT_WIDTH = mme_pkg::ELEMENT_WIDTH_DEF,
	parameter int IDX_W         = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_accept,
	input  logic [mme_pkg::CMD_W-1:0]             in_cmd,
	input  logic [mme_pkg::IDX_PORT_W-1:0]        in_row,
	input  logic [mme_pkg::IDX_PORT_W-1:0]        in_col,
	input  logic [mme_pkg::VALUE_W-1:0]           in_value,
	input  mme_pkg::dp_cmd_t                      dp_cmd,
	output mme_pkg::dp_status_t                   dp_status,
	input  logic [IDX_W-1:0]                      row_idx,
	input  logic [IDX_W-1:0]                      col_idx,
	input  logic [IDX_W-1:0]                      k_idx,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [mme_pkg::OUT_TDATA_W-1:0]       out_data,
	output logic                                  out_last
);

	localparam int EW     = (ELEMENT_WIDTH < mme_pkg::VALUE_W) ? ELEMENT_WIDTH : mme_pkg::VALUE_W;
	localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PROD_W = 2 * EW;
	localparam int PAD_W  = mme_pkg::OUT_TDATA_W - 2 * mme_pkg::IDX_PORT_W - mme_pkg::ACC_W;
	localparam logic [mme_pkg::IDX_PORT_W:0] MAX_IDX = (mme_pkg::IDX_PORT_W + 1)'(MAX_SIZE);

	logic [EW-1:0]            mem_a [DEPTH];
	logic [EW-1:0]            mem_b [DEPTH];
	logic                     in_range;
	logic                     wr_a;
	logic                     wr_b;
	logic [ADDR_W-1:0]        wr_addr_a;
	logic [ADDR_W-1:0]        wr_addr_b;
	logic [ADDR_W-1:0]        rd_addr_a;
	logic [ADDR_W-1:0]        rd_addr_b;
	logic signed [EW-1:0]     a_s1;
	logic signed [EW-1:0]     b_s1;
	logic                     v_s1;
	logic                     first_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     v_s2;
	logic                     first_s2;
	logic signed [mme_pkg::ACC_W-1:0] acc_q;
	logic                     out_valid_q;
	logic [mme_pkg::IDX_PORT_W-1:0] out_row_q;
	logic [mme_pkg::IDX_PORT_W-1:0] out_col_q;
	logic [mme_pkg::ACC_W-1:0] out_value_q;
	logic                     out_last_q;

	assign in_range = ({1'b0, in_row} < MAX_IDX) && ({1'b0, in_col} < MAX_IDX);
	assign wr_a = in_accept && in_range && (in_cmd == mme_pkg::CMD_LOAD_A);
	assign wr_b = in_accept && in_range && (in_cmd == mme_pkg::CMD_LOAD_B);

	// A is kept row-major and B column-major, so both reads step along k.
	assign wr_addr_a = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_SIZE) + ADDR_W'(in_col));
	assign wr_addr_b = ADDR_W'(ADDR_W'(in_col) * ADDR_W'(MAX_SIZE) + ADDR_W'(in_row));
	assign rd_addr_a = ADDR_W'(ADDR_W'(row_idx) * ADDR_W'(MAX_SIZE) + ADDR_W'(k_idx));
	assign rd_addr_b = ADDR_W'(ADDR_W'(col_idx) * ADDR_W'(MAX_SIZE) + ADDR_W'(k_idx));

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr_a] <= in_value[EW-1:0];
		end
		if (dp_cmd.rd_en) begin
			a_s1 <= mem_a[rd_addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[wr_addr_b] <= in_value[EW-1:0];
		end
		if (dp_cmd.rd_en) begin
			b_s1 <= mem_b[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= dp_cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= dp_cmd.first;
		first_s2 <= first_s1;
		prod_s2  <= a_s1 * b_s1;
		if (v_s2) begin
			if (first_s2) begin
				acc_q <= mme_pkg::ACC_W'(prod_s2);
			end else begin
				acc_q <= acc_q + mme_pkg::ACC_W'(prod_s2);
			end
		end
	end

	assign dp_status.pipe_busy = v_s1 || v_s2;
	assign dp_status.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.emit) begin
			out_row_q   <= mme_pkg::IDX_PORT_W'(row_idx);
			out_col_q   <= mme_pkg::IDX_PORT_W'(col_idx);
			out_value_q <= acc_q;
			out_last_q  <= dp_cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {{PAD_W{1'b0}}, out_value_q, out_col_q, out_row_q};
	assign out_last  = out_last_q;

endmodule

@@ hw/rtl/matrix_multiply_engine_core.sv @@
// Top level of the matrix multiply engine: controller and datapath.
//
// Requests enter on the s_axis channel. tuser carries the command: load an
// element of A, load an element of B, or compute. tdata carries row, column
// and the signed element value. A load is stored and yields nothing;
// loads may arrive back to back. A compute request multiplies the first
// active_rows rows of A by all matrix_size columns of B and returns one
// result per element on m_axis, row by row, with tlast on the final one.
// Each result is accumulated over matrix_size products through the
// single multiplier, then the pipeline drains and the result is emitted;
// s_axis_tready is low for the whole compute run. The result sits in an
// output register; when the receiver stalls, the sequencer holds until
// that register frees up.
// Configuration writes on the cfg channel are always taken: index 0 sets
// matrix_size, index 1 sets active_rows; both reset to 8. After reset the
// element memories hold no defined values until loaded.
module matrix_multiply_engine_core #(
	parameter int MAX_SIZE      = mme_pkg::MAX_SIZE_DEF,
	parameter int ELEMENT_WIDTH = mme_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [2:0] row, [5:3] col, [21:6] value, [23:22] zero
	input  logic [mme_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] command
	input  logic [mme_pkg::CMD_W-1:0]          s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [2:0] out_row, [5:3] out_col, [40:6] out_value, [47:41] zero
	output logic [mme_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                               m_axis_tlast,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mme_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mme_pkg::CFG_W-1:0]          cfg_data
);

	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

	mme_pkg::dp_cmd_t    dp_cmd;
	mme_pkg::dp_status_t dp_status;
	logic [IDX_W-1:0]    row_idx;
	logic [IDX_W-1:0]    col_idx;
	logic [IDX_W-1:0]    k_idx;
	logic                in_accept;

	assign cfg_ready = 1'b1;
	assign in_accept = s_axis_tvalid && s_axis_tready;

	mme_ctrl #(
		.MAX_SIZE (MAX_SIZE),
		.IDX_W    (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_cmd    (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.k_idx     (k_idx)
	);

	mme_datapath #(
		.MAX_SIZE      (MAX_SIZE),
		.ELEMENT_WIDTH (ELEMENT_WIDTH),
		.IDX_W         (IDX_W)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_cmd    (s_axis_tuser),
		.in_row    (s_axis_tdata[2:0]),
		.in_col    (s_axis_tdata[5:3]),
		.in_value  (s_axis_tdata[21:6]),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status),
		.row_idx   (row_idx),
		.col_idx   (col_idx),
		.k_idx     (k_idx),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
